FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the stopwatch bank.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define NSW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsw assertion failed");

// Next-cycle implication, disabled while in reset.
`define NSW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsw assertion failed");

`endif

FILE: rtl/nsw_pkg.sv
// ----------------------------------------------------------------------------
// nsw_pkg
// Types, codes and defaults shared by the stopwatch bank modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsw_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int NEST_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_MERGE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_IDLE_STOP = 2'd1,
    FAULT_SAT       = 2'd2
  } fault_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FOLD
  } st_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  timer_id;
    logic [63:0] now_us;
    logic [31:0] merge_intervals;
    logic [63:0] merge_total_us;
    logic [63:0] merge_shortest_us;
    logic [63:0] merge_longest_us;
  } in_t;

  typedef struct packed {
    logic [3:0]  addressed_timer;
    logic        used;
    logic        running;
    logic [31:0] interval_total;
    logic [63:0] elapsed_total_us;
    logic [63:0] shortest_us;
    logic [63:0] longest_us;
    fault_t      fault;
  } out_t;

  // Per-timer statistics as kept in the table.
  typedef struct packed {
    logic [31:0] count;
    logic [63:0] sum;
    logic [63:0] min;
    logic [63:0] max;
  } stats_t;

  // Request to fold a batch of intervals into a timer's stats.
  typedef struct packed {
    logic        en;
    logic [31:0] count;
    logic [63:0] total;
    logic [63:0] lo;
    logic [63:0] hi;
  } fold_req_t;

endpackage

FILE: rtl/nsw_store.sv
// ----------------------------------------------------------------------------
// nsw_store
// Timer table: one write port, one registered read port, per-entry valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nsw_store #(
  parameter int NUM_TIMERS = nsw_pkg::NUM_TIMERS_DEF,
  parameter int NEST_BITS  = nsw_pkg::NEST_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   rd_en,
  input  logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] rd_addr,
  input  logic                                   wr_en,
  input  logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] wr_addr,
  input  logic [NEST_BITS-1:0]                   wr_depth,
  input  logic [63:0]                            wr_start,
  input  nsw_pkg::stats_t                        wr_stats,
  output logic [NEST_BITS-1:0]                   rd_depth,
  output logic [63:0]                            rd_start,
  output nsw_pkg::stats_t                        rd_stats
);

  localparam int WORD_W = NEST_BITS + 64 + $bits(nsw_pkg::stats_t);

  logic [WORD_W-1:0]     mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] valid;
  logic [WORD_W-1:0]     rd_word;
  logic                  rd_hit;
  logic [WORD_W-1:0]     rd_view;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_depth, wr_start, wr_stats};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
    end
  end

  assign rd_view  = rd_hit ? rd_word : '0;
  assign rd_depth = rd_view[WORD_W-1 -: NEST_BITS];
  assign rd_start = rd_view[$bits(nsw_pkg::stats_t) +: 64];
  assign rd_stats = rd_view[$bits(nsw_pkg::stats_t)-1:0];

  `NSW_ASSERT_IMPL(a_no_rw_overlap, clk, rst, wr_en, !rd_en)

endmodule

FILE: rtl/nsw_fold.sv
// ----------------------------------------------------------------------------
// nsw_fold
// Folds a batch of intervals into one timer's stats; saturating count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsw_fold (
  input  nsw_pkg::stats_t   old_stats,
  input  nsw_pkg::fold_req_t req,
  output nsw_pkg::stats_t   new_stats,
  output logic              sat
);

  logic [32:0] cnt_sum;

  always_comb begin
    cnt_sum   = {1'b0, old_stats.count} + {1'b0, req.count};
    new_stats = old_stats;
    sat       = 1'b0;
    if (req.en) begin
      new_stats.sum = old_stats.sum + req.total;
      if (old_stats.count == 32'd0) begin
        new_stats.min = req.lo;
        new_stats.max = req.hi;
      end else begin
        new_stats.min = (req.lo < old_stats.min) ? req.lo : old_stats.min;
        new_stats.max = (req.hi > old_stats.max) ? req.hi : old_stats.max;
      end
      sat             = cnt_sum[32];
      new_stats.count = cnt_sum[32] ? '1 : cnt_sum[31:0];
    end
  end

endmodule

FILE: rtl/nested_stopwatch_stats_bank.sv
// Sequencing: an item is accepted only while the sequencer is idle, so a new item
//   waits until the last one is through; each item does a table read, a
//   decode/interval stage and a fold/write-back (which waits while the result side stalls).
// Reset (rst, synchronous): all timers read as zero (valid bits cleared at
//   once, no sweep), sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// nested_stopwatch_stats_bank
// Bank of nesting stopwatches with per-timer interval statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nested_stopwatch_stats_bank #(
  parameter int NUM_TIMERS = nsw_pkg::NUM_TIMERS_DEF,
  parameter int NEST_BITS  = nsw_pkg::NEST_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  nsw_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output nsw_pkg::out_t result
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [NEST_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [NEST_BITS-1:0] DEPTH_ONE = NEST_BITS'(1);

  // Sequencer
  nsw_pkg::st_t state, state_next;
  logic accept, look_go, fold_done;

  // Item held for the duration of its update
  nsw_pkg::in_t item_q;
  logic         in_range_q;
  logic         item_in_range;
  logic [IDX_W+3:0] id_wide;
  logic [IDX_W-1:0] item_addr;
  logic [IDX_W+3:0] q_wide;
  logic [IDX_W-1:0] q_addr;

  // Table port
  logic                 rd_en, wr_en;
  logic [NEST_BITS-1:0] rd_depth;
  logic [63:0]          rd_start;
  nsw_pkg::stats_t      rd_stats;

  // Decode stage results
  logic [NEST_BITS-1:0] depth_n, depth_q;
  logic [63:0]          start_n, start_q;
  nsw_pkg::fold_req_t   req_n, req_q;
  nsw_pkg::fault_t      fault_n, fault_q;
  nsw_pkg::stats_t      stats_q;
  logic [63:0]          interval;

  // Fold stage
  nsw_pkg::stats_t stats_new;
  logic            sat;

  // Check helper
  logic idle_stop_out;

  // ---- address and range ---------------------------------------------------
  // Timer ids at or above NUM_TIMERS touch nothing and report zeros.
  assign item_in_range = 32'(item.timer_id) < 32'(NUM_TIMERS);
  assign id_wide       = {{IDX_W{1'b0}}, item.timer_id};
  assign item_addr     = id_wide[IDX_W-1:0];
  assign q_wide        = {{IDX_W{1'b0}}, item_q.timer_id};
  assign q_addr        = q_wide[IDX_W-1:0];

  // ---- sequencer --------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      nsw_pkg::ST_IDLE: if (item_valid) state_next = nsw_pkg::ST_LOOK;
      nsw_pkg::ST_LOOK: state_next = nsw_pkg::ST_FOLD;
      nsw_pkg::ST_FOLD: if (!result_valid || !result_stall) state_next = nsw_pkg::ST_IDLE;
      default:          state_next = nsw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = (state != nsw_pkg::ST_IDLE);
    accept     = item_valid && (state == nsw_pkg::ST_IDLE);
    look_go    = (state == nsw_pkg::ST_LOOK);
    // The fold waits for the output register to be free.
    fold_done  = (state == nsw_pkg::ST_FOLD) && (!result_valid || !result_stall);
    rd_en      = accept && item_in_range;
    wr_en      = fold_done && in_range_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q     <= item;
      in_range_q <= item_in_range;
    end
  end

  // ---- timer table ------------------------------------------------------------
  nsw_store #(
    .NUM_TIMERS(NUM_TIMERS),
    .NEST_BITS (NEST_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (item_addr),
    .wr_en   (wr_en),
    .wr_addr (q_addr),
    .wr_depth(depth_q),
    .wr_start(start_q),
    .wr_stats(stats_new),
    .rd_depth(rd_depth),
    .rd_start(rd_start),
    .rd_stats(rd_stats)
  );

  // ---- decode stage: nesting and interval --------------------------------------
  // Start bumps the depth (latching time only on the outermost start); stop
  // drops it and closes an interval when it returns to zero. Merge forwards
  // the external batch unless it is empty.
  assign interval = item_q.now_us - rd_start;

  always_comb begin
    depth_n   = rd_depth;
    start_n   = rd_start;
    fault_n   = nsw_pkg::FAULT_NONE;
    req_n.en    = 1'b0;
    req_n.count = item_q.merge_intervals;
    req_n.total = item_q.merge_total_us;
    req_n.lo    = item_q.merge_shortest_us;
    req_n.hi    = item_q.merge_longest_us;
    unique case (item_q.mode)
      nsw_pkg::MODE_START: begin
        if (rd_depth == DEPTH_MAX) begin
          fault_n = nsw_pkg::FAULT_SAT;
        end else begin
          depth_n = rd_depth + DEPTH_ONE;
          if (rd_depth == '0) begin
            start_n = item_q.now_us;
          end
        end
      end
      nsw_pkg::MODE_STOP: begin
        if (rd_depth == '0) begin
          fault_n = nsw_pkg::FAULT_IDLE_STOP;
        end else begin
          depth_n = rd_depth - DEPTH_ONE;
          if (rd_depth == DEPTH_ONE) begin
            req_n.en    = 1'b1;
            req_n.count = 32'd1;
            req_n.total = interval;
            req_n.lo    = interval;
            req_n.hi    = interval;
          end
        end
      end
      nsw_pkg::MODE_MERGE: begin
        req_n.en = (item_q.merge_intervals != 32'd0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (look_go) begin
      depth_q <= depth_n;
      start_q <= start_n;
      fault_q <= fault_n;
      req_q   <= req_n;
      stats_q <= rd_stats;
    end
  end

  // ---- fold stage and result register -------------------------------------------
  nsw_fold u_fold (
    .old_stats(stats_q),
    .req      (req_q),
    .new_stats(stats_new),
    .sat      (sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fold_done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fold_done) begin
      result.addressed_timer <= item_q.timer_id;
      if (in_range_q) begin
        result.used             <= (stats_new.count != 32'd0);
        result.running          <= (depth_q != '0);
        result.interval_total   <= stats_new.count;
        result.elapsed_total_us <= stats_new.sum;
        result.shortest_us      <= stats_new.min;
        result.longest_us       <= stats_new.max;
        result.fault            <= (fault_q != nsw_pkg::FAULT_NONE) ? fault_q :
                                   (sat ? nsw_pkg::FAULT_SAT : nsw_pkg::FAULT_NONE);
      end else begin
        result.used             <= 1'b0;
        result.running          <= 1'b0;
        result.interval_total   <= '0;
        result.elapsed_total_us <= '0;
        result.shortest_us      <= '0;
        result.longest_us       <= '0;
        result.fault            <= nsw_pkg::FAULT_NONE;
      end
    end
  end

  // ---- checks -------------------------------------------------------------------
  assign idle_stop_out = fold_done && (fault_q == nsw_pkg::FAULT_IDLE_STOP);

  `NSW_ASSERT_NEXT(a_accept_to_look, clk, rst, accept, state == nsw_pkg::ST_LOOK)
  `NSW_ASSERT_IMPL(a_write_in_fold, clk, rst, wr_en, state == nsw_pkg::ST_FOLD)
  `NSW_ASSERT_IMPL(a_result_from_fold, clk, rst, $rose(result_valid), $past(fold_done))
  `NSW_ASSERT_IMPL(a_idle_stop_mode, clk, rst, idle_stop_out, item_q.mode == nsw_pkg::MODE_STOP)

endmodule

FILE: dv/stats_bank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stats_bank_checker
// Watches the item and result channels and keeps a shadow timer table.
// Every result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module stats_bank_checker
  import nsw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  input  logic item_stall,
  input  in_t  item,
  input  logic result_valid,
  input  logic result_stall,
  input  out_t result,
  output int   pending,
  output int   failures
);

  localparam int TIMERS = NUM_TIMERS_DEF;
  localparam logic [NEST_BITS_DEF-1:0] DEPTH_TOP = '1;
  localparam logic [NEST_BITS_DEF-1:0] DEPTH_ONE = NEST_BITS_DEF'(1);

  // Shadow of the timer table.
  logic [NEST_BITS_DEF-1:0] depth     [TIMERS];
  logic [63:0]              opened_at [TIMERS];
  logic [63:0]              sum_us    [TIMERS];
  logic [63:0]              min_us    [TIMERS];
  logic [63:0]              max_us    [TIMERS];
  logic [31:0]              closed    [TIMERS];

  out_t expected_stats [$];
  int   mismatches = 0;

  // Folds n intervals into timer t; returns 1 when the count saturates.
  function automatic bit fold_stats(int t, logic [31:0] n, logic [63:0] total,
                                    logic [63:0] lo, logic [63:0] hi);
    logic [32:0] cnt;
    sum_us[t] += total;
    if (closed[t] == '0) begin
      min_us[t] = lo;
      max_us[t] = hi;
    end else begin
      if (lo < min_us[t]) min_us[t] = lo;
      if (hi > max_us[t]) max_us[t] = hi;
    end
    cnt = {1'b0, closed[t]} + {1'b0, n};
    closed[t] = cnt[32] ? '1 : cnt[31:0];
    return cnt[32];
  endfunction

  // Applies one word to the shadow table and returns the stats it reports.
  function automatic out_t predict_stats(in_t w);
    out_t        r;
    int          t;
    logic [63:0] span;
    r = '0;
    t = int'(w.timer_id);
    r.addressed_timer = w.timer_id;
    r.fault = FAULT_NONE;
    if (t < TIMERS) begin
      case (w.mode)
        MODE_START: begin
          if (depth[t] == DEPTH_TOP) begin
            r.fault = FAULT_SAT;
          end else begin
            depth[t] += DEPTH_ONE;
            if (depth[t] == DEPTH_ONE) opened_at[t] = w.now_us;
          end
        end
        MODE_STOP: begin
          if (depth[t] == '0) begin
            r.fault = FAULT_IDLE_STOP;
          end else begin
            depth[t] -= DEPTH_ONE;
            if (depth[t] == '0) begin
              span = w.now_us - opened_at[t];
              if (fold_stats(t, 32'd1, span, span, span)) r.fault = FAULT_SAT;
            end
          end
        end
        MODE_MERGE: begin
          if (w.merge_intervals != '0) begin
            if (fold_stats(t, w.merge_intervals, w.merge_total_us,
                           w.merge_shortest_us, w.merge_longest_us))
              r.fault = FAULT_SAT;
          end
        end
        default: ;
      endcase
      r.used             = closed[t] != '0;
      r.running          = depth[t] != '0;
      r.interval_total   = closed[t];
      r.elapsed_total_us = sum_us[t];
      r.shortest_us      = min_us[t];
      r.longest_us       = max_us[t];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      for (int i = 0; i < TIMERS; i++) begin
        depth[i]     = '0;
        opened_at[i] = '0;
        sum_us[i]    = '0;
        min_us[i]    = '0;
        max_us[i]    = '0;
        closed[i]    = '0;
      end
      expected_stats.delete();
    end else begin
      if (item_valid && !item_stall) expected_stats.push_back(predict_stats(item));
      if (result_valid && !result_stall) begin
        if (expected_stats.size() == 0) begin
          $error("result word with no prediction waiting");
          mismatches++;
        end else begin
          want = expected_stats.pop_front();
          check_field("addressed_timer", 64'(want.addressed_timer),
                      64'(result.addressed_timer));
          check_field("used", 64'(want.used), 64'(result.used));
          check_field("running", 64'(want.running), 64'(result.running));
          check_field("interval_total", 64'(want.interval_total),
                      64'(result.interval_total));
          check_field("elapsed_total_us", want.elapsed_total_us, result.elapsed_total_us);
          check_field("shortest_us", want.shortest_us, result.shortest_us);
          check_field("longest_us", want.longest_us, result.longest_us);
          check_field("fault", 64'(want.fault), 64'(result.fault));
        end
      end
    end
    pending  <= expected_stats.size();
    failures <= mismatches;
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the nesting stopwatch bank. A short directed
// pass hits the corner cases, then random start/stop/merge/read traffic runs
// with random gaps on the item side and random stalls on the result side.
// Checking is done by stats_bank_checker.
// ----------------------------------------------------------------------------

module testbench;
  import nsw_pkg::*;

  localparam int RANDOM_WORDS = 1600;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES = 8;     // extra idle margin after the final drain
  localparam int CLIMB_STARTS = 1 << NEST_BITS_DEF;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic item_valid   = 1'b0;
  logic item_stall;
  in_t  item         = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_t result;

  int   pending;
  int   failures;

  // calm turns off idling on both sides for a stretch of the random run
  logic calm  = 1'b0;
  int   quiet = 0;
  int   sent  = 0;

  // Stimulus-side guess of each timer's nesting depth, used only to bias
  // the random traffic toward well-formed start/stop pairs.
  int unsigned open_depth [NUM_TIMERS_DEF];
  logic [63:0] wall_us;

  always #5 clk = ~clk;

  nested_stopwatch_stats_bank dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  stats_bank_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .pending      (pending),
    .failures     (failures)
  );

  // Result side back-pressure: roughly a third of the cycles stalled.
  always @(posedge clk) begin
    result_stall <= !rst && !calm && ($urandom_range(0, 99) < 34);
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Unused fields of a word still get random content.
  function automatic in_t make_word(mode_t m, logic [3:0] t, logic [63:0] now);
    in_t w;
    w.mode              = m;
    w.timer_id          = t;
    w.now_us            = now;
    w.merge_intervals   = $urandom;
    w.merge_total_us    = rand64();
    w.merge_shortest_us = rand64();
    w.merge_longest_us  = rand64();
    return w;
  endfunction

  // Offers one word and returns at the edge where it is taken. Random idle
  // cycles go in front of the word; valid stays up across back-to-back words.
  task automatic send_word(in_t w);
    while (!calm && $urandom_range(0, 99) < 34) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  // Stops offering and waits until every predicted word has come back.
  // The first edge lets the checker count the word just taken.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_t         w;
    logic [3:0]  t;
    int unsigned pick;
    int unsigned sel;
    bit          climbed;
    bit          paused;

    climbed = 1'b0;
    paused  = 1'b0;
    foreach (open_depth[i]) open_depth[i] = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // ---- directed corners ----
    send_word(make_word(MODE_READ, 4'd0, '0));          // fresh timer reads zero
    send_word(make_word(MODE_STOP, 4'd1, '1));          // stop while idle
    send_word(make_word(MODE_START, 4'd2, '0));
    send_word(make_word(MODE_STOP, 4'd2, '1));          // longest possible interval
    send_word(make_word(MODE_START, 4'd3, '1));
    send_word(make_word(MODE_STOP, 4'd3, 64'd5));       // time wraps past 2^64
    send_word(make_word(MODE_START, 4'd4, 64'd100));
    send_word(make_word(MODE_START, 4'd4, 64'd200));    // inner start keeps 100
    send_word(make_word(MODE_STOP, 4'd4, 64'd300));
    send_word(make_word(MODE_STOP, 4'd4, 64'd400));     // closes: 300 us
    w = make_word(MODE_MERGE, 4'd5, '1);
    w.merge_intervals = '0;                             // empty merge, ignored
    send_word(w);
    w = make_word(MODE_MERGE, 4'd5, '0);
    w.merge_intervals   = '1;
    w.merge_total_us    = '1;
    w.merge_shortest_us = '1;
    w.merge_longest_us  = '1;
    send_word(w);
    w = make_word(MODE_MERGE, 4'd5, '0);
    w.merge_intervals   = 32'd1;                        // count saturates on merge
    w.merge_total_us    = 64'd1;
    w.merge_shortest_us = '0;
    w.merge_longest_us  = '0;
    send_word(w);
    send_word(make_word(MODE_START, 4'd5, 64'd10));
    send_word(make_word(MODE_STOP, 4'd5, 64'd20));      // count saturates on stop
    w = make_word(MODE_MERGE, 4'd15, '0);
    w.merge_intervals   = 32'd3;
    w.merge_total_us    = 64'd30;
    w.merge_shortest_us = 64'd5;
    w.merge_longest_us  = 64'd15;
    send_word(w);
    w = make_word(MODE_MERGE, 4'd15, '0);
    w.merge_intervals   = 32'd2;
    w.merge_total_us    = 64'd0;
    w.merge_shortest_us = 64'd7;                        // neither new min nor max
    w.merge_longest_us  = 64'd20;                       // new max
    send_word(w);
    send_word(make_word(MODE_READ, 4'd15, '1));
    send_word(make_word(MODE_START, 4'd15, 64'd1000));
    send_word(make_word(MODE_READ, 4'd15, '0));         // running flag now set
    open_depth[15] = 1;

    // Hold the sender until the block is empty.
    wait_drained();

    // ---- random traffic ----
    sent    = 0;
    wall_us = rand64();
    while (sent < RANDOM_WORDS) begin
      calm <= (sent >= 700 && sent < 1000);

      if (!climbed && sent >= 300) begin
        // Drive one timer to the nesting ceiling and back down, ending with
        // one stop too many.
        t = 4'($urandom_range(0, NUM_TIMERS_DEF - 1));
        repeat (CLIMB_STARTS) begin
          wall_us += 64'($urandom_range(1, 50));
          send_word(make_word(MODE_START, t, wall_us));
        end
        send_word(make_word(MODE_READ, t, wall_us));
        repeat (CLIMB_STARTS) begin
          wall_us += 64'($urandom_range(1, 50));
          send_word(make_word(MODE_STOP, t, wall_us));
        end
        open_depth[t] = 0;
        climbed = 1'b1;
      end else if (!paused && sent >= 1200) begin
        wait_drained();
        paused = 1'b1;
      end else begin
        t    = 4'($urandom_range(0, NUM_TIMERS_DEF - 1));
        pick = $urandom_range(0, 99);
        // Mostly steady time; now and then a jump anywhere, which also
        // produces wrapped intervals.
        if ($urandom_range(0, 99) < 3) wall_us = rand64();
        else wall_us += 64'($urandom_range(1, 5000));

        if (pick < 10) begin
          w   = make_word(MODE_MERGE, t, wall_us);
          sel = $urandom_range(0, 99);
          if (sel < 10) w.merge_intervals = '0;
          else if (sel < 97) w.merge_intervals = $urandom_range(1, 200);
          // otherwise keep the full-width random count
        end else if (pick < 20) begin
          w = make_word(MODE_READ, t, wall_us);
        end else if (open_depth[t] >= 4 || (open_depth[t] != 0 && pick >= 60) ||
                     (open_depth[t] == 0 && pick >= 94)) begin
          w = make_word(MODE_STOP, t, wall_us);
          if (open_depth[t] != 0) open_depth[t]--;
        end else begin
          w = make_word(MODE_START, t, wall_us);
          open_depth[t]++;
        end
        send_word(w);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
